/* src/dpm_pp_pkg.sv */
// ----------------------------------------------------------------------------
// dpm_pp_pkg
// shared types, constants and helpers of the second-order latent update
// ----------------------------------------------------------------------------
package dpm_pp_pkg;

    localparam int DATA_W      = 32;
    localparam int INDEX_W     = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int ACC_W       = 35;
    localparam int STEP_W      = 5;
    localparam int PASS_W      = 2;
    localparam int MAX_ELEMENTS_DEF = 65536;

    localparam logic [PASS_W-1:0] PASS_MAX = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_SIGMA_NOW     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_ALPHA     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_SCALE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_COEFF    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HISTORY_COEFF = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FINAL_STEP    = 3'd5;

    localparam logic signed [DATA_W-1:0] INV_ALPHA_RST = 32'sd1048576;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_M1,
        ST_M3,
        ST_T,
        ST_M2,
        ST_WAIT,
        ST_X0,
        ST_M5,
        ST_A4,
        ST_A5,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_store_req;

    // compare-subtract steps that bring a 16-bit index below m
    function automatic int f_mod_steps(input int m);
        int k;
        k = 0;
        for (int i = 0; i < 17; i++) begin
            if ((longint'(m) << i) <= 65535) begin
                k = i + 1;
            end
        end
        return k;
    endfunction

    function automatic logic signed [DATA_W-1:0] f_sat(input logic signed [ACC_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > 35'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -35'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

/* src/dpm_pp_if.sv */
// ----------------------------------------------------------------------------
// dpm_pp interfaces
// valid/ready channels for elements, results and register writes
// ----------------------------------------------------------------------------
interface dpm_pp_in_if;
    logic                                    valid;
    logic                                    ready;
    logic        [dpm_pp_pkg::INDEX_W-1:0]   element_index;
    logic signed [dpm_pp_pkg::DATA_W-1:0]    eps_value;
    logic signed [dpm_pp_pkg::DATA_W-1:0]    sample_value;
    logic                                    last_of_pass;

    modport source (output valid, element_index, eps_value, sample_value, last_of_pass,
                    input ready);
    modport sink (input valid, element_index, eps_value, sample_value, last_of_pass,
                  output ready);
endinterface

interface dpm_pp_out_if;
    logic                                    valid;
    logic                                    ready;
    logic        [dpm_pp_pkg::INDEX_W-1:0]   out_index;
    logic signed [dpm_pp_pkg::DATA_W-1:0]    new_value;
    logic                                    out_last;

    modport source (output valid, out_index, new_value, out_last, input ready);
    modport sink (input valid, out_index, new_value, out_last, output ready);
endinterface

interface dpm_pp_cfg_if;
    logic                                    valid;
    logic                                    ready;
    logic [dpm_pp_pkg::CFG_IDX_W-1:0]        index;
    logic [dpm_pp_pkg::DATA_W-1:0]           data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* src/dpm_pp_mul.sv */
// ----------------------------------------------------------------------------
// dpm_pp_mul
// pipelined Q12.20 x Q8.24 multiplier, round half up, saturate to 32 bits
// ----------------------------------------------------------------------------
module dpm_pp_mul (
    input  logic                                  i_clk,
    input  logic signed [dpm_pp_pkg::DATA_W-1:0]  i_a,
    input  logic signed [dpm_pp_pkg::DATA_W-1:0]  i_b,
    output logic signed [dpm_pp_pkg::DATA_W-1:0]  o_q
);

    logic signed [63:0] r_prod;
    logic signed [63:0] w_sum;
    logic signed [63:0] w_shift;
    logic signed [dpm_pp_pkg::DATA_W-1:0] n_q;
    logic signed [dpm_pp_pkg::DATA_W-1:0] r_q;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
        r_q    <= n_q;
    end

    always_comb begin
        w_sum   = r_prod + 64'sd524288;
        w_shift = w_sum >>> 20;
        if (w_shift > 64'sd2147483647) begin
            n_q = 32'sh7fffffff;
        end else if (w_shift < -64'sd2147483648) begin
            n_q = 32'sh80000000;
        end else begin
            n_q = w_shift[dpm_pp_pkg::DATA_W-1:0];
        end
    end

    assign o_q = r_q;

endmodule

/* src/dpm_pp_store.sv */
// ----------------------------------------------------------------------------
// dpm_pp_store
// per-element estimate memory, read and write share one address, registered read
// ----------------------------------------------------------------------------
module dpm_pp_store #(
    parameter int DEPTH  = dpm_pp_pkg::MAX_ELEMENTS_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                                  i_clk,
    input  dpm_pp_pkg::t_store_req                i_req,
    input  logic        [ADDR_W-1:0]              i_addr,
    input  logic signed [dpm_pp_pkg::DATA_W-1:0]  i_wr_data,
    output logic signed [dpm_pp_pkg::DATA_W-1:0]  o_rd_data
);

    logic signed [dpm_pp_pkg::DATA_W-1:0] r_mem [DEPTH];
    logic signed [dpm_pp_pkg::DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* src/dpm_solver_pp_update.sv */
// ----------------------------------------------------------------------------
// dpm_solver_pp_update
// second-order multistep latent update with per-element estimate history
// ----------------------------------------------------------------------------
// sequence: after an element is taken, K index reduction steps (K = 0 when
//   MAX_ELEMENTS >= 65536), then states M1, M3, T, M2, WAIT, X0, M5, A4, A5, DONE
// flow: no new element is taken until the last one leaves DONE; the multiplier is shared
// reset: configuration and control registers return to their reset values, pass
//   counter clears, the estimate memory is not cleared and holds garbage until written
module dpm_solver_pp_update #(
    parameter int MAX_ELEMENTS = dpm_pp_pkg::MAX_ELEMENTS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    dpm_pp_in_if.sink     i_in,
    dpm_pp_out_if.source  o_out,
    dpm_pp_cfg_if.sink    i_cfg
);

    localparam int ADDR_W    = $clog2(MAX_ELEMENTS);
    localparam int MOD_STEPS = dpm_pp_pkg::f_mod_steps(MAX_ELEMENTS);
    localparam int DW        = dpm_pp_pkg::DATA_W;
    localparam int AW        = dpm_pp_pkg::ACC_W;

    // configuration
    logic signed [DW-1:0] r_sigma_now;
    logic signed [DW-1:0] r_inv_alpha;
    logic signed [DW-1:0] r_sample_scale;
    logic signed [DW-1:0] r_base_coeff;
    logic signed [DW-1:0] r_history_coeff;
    logic                 r_final_step;

    // control
    dpm_pp_pkg::t_state   r_state;
    dpm_pp_pkg::t_state   n_state;
    logic [dpm_pp_pkg::STEP_W-1:0] r_step;
    logic [dpm_pp_pkg::PASS_W-1:0] r_pass;
    logic                 r_out_valid;

    // item
    logic [dpm_pp_pkg::INDEX_W-1:0] r_index;
    logic [dpm_pp_pkg::INDEX_W-1:0] r_rem;
    logic signed [DW-1:0] r_eps;
    logic signed [DW-1:0] r_x;
    logic                 r_last;
    logic                 r_second;
    logic signed [DW-1:0] r_t;
    logic signed [DW-1:0] r_x0;
    logic signed [DW-1:0] r_d;
    logic signed [AW-1:0] r_acc;

    // result register
    logic [dpm_pp_pkg::INDEX_W-1:0] r_out_index;
    logic signed [DW-1:0] r_out_value;
    logic                 r_out_last;

    logic signed [DW-1:0] w_mul_a;
    logic signed [DW-1:0] w_mul_b;
    logic signed [DW-1:0] w_mul_q;
    logic signed [DW-1:0] w_prev;
    dpm_pp_pkg::t_store_req w_store_req;
    logic                 w_in_ready;
    logic                 w_done_go;
    logic [31:0]          w_mod_const;
    logic [ADDR_W-1:0]    w_addr;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sigma_now     <= '0;
            r_inv_alpha     <= dpm_pp_pkg::INV_ALPHA_RST;
            r_sample_scale  <= '0;
            r_base_coeff    <= '0;
            r_history_coeff <= '0;
            r_final_step    <= 1'b0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                dpm_pp_pkg::CFG_SIGMA_NOW:     r_sigma_now     <= i_cfg.data;
                dpm_pp_pkg::CFG_INV_ALPHA:     r_inv_alpha     <= i_cfg.data;
                dpm_pp_pkg::CFG_SAMPLE_SCALE:  r_sample_scale  <= i_cfg.data;
                dpm_pp_pkg::CFG_BASE_COEFF:    r_base_coeff    <= i_cfg.data;
                dpm_pp_pkg::CFG_HISTORY_COEFF: r_history_coeff <= i_cfg.data;
                dpm_pp_pkg::CFG_FINAL_STEP:    r_final_step    <= i_cfg.data[0];
                default: begin
                end
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            dpm_pp_pkg::ST_IDLE: begin
                if (i_in.valid) begin
                    n_state = dpm_pp_pkg::ST_REDUCE;
                end
            end
            dpm_pp_pkg::ST_REDUCE: begin
                if (r_step == '0) begin
                    n_state = dpm_pp_pkg::ST_M1;
                end
            end
            dpm_pp_pkg::ST_M1:   n_state = dpm_pp_pkg::ST_M3;
            dpm_pp_pkg::ST_M3:   n_state = dpm_pp_pkg::ST_T;
            dpm_pp_pkg::ST_T:    n_state = dpm_pp_pkg::ST_M2;
            dpm_pp_pkg::ST_M2:   n_state = dpm_pp_pkg::ST_WAIT;
            dpm_pp_pkg::ST_WAIT: n_state = dpm_pp_pkg::ST_X0;
            dpm_pp_pkg::ST_X0:   n_state = dpm_pp_pkg::ST_M5;
            dpm_pp_pkg::ST_M5:   n_state = dpm_pp_pkg::ST_A4;
            dpm_pp_pkg::ST_A4:   n_state = dpm_pp_pkg::ST_A5;
            dpm_pp_pkg::ST_A5:   n_state = dpm_pp_pkg::ST_DONE;
            dpm_pp_pkg::ST_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    n_state = dpm_pp_pkg::ST_IDLE;
                end
            end
            default: n_state = dpm_pp_pkg::ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        w_in_ready        = 1'b0;
        w_done_go         = 1'b0;
        w_store_req.rd_en = 1'b0;
        w_store_req.wr_en = 1'b0;
        w_mul_a           = '0;
        w_mul_b           = '0;
        case (r_state)
            dpm_pp_pkg::ST_IDLE: w_in_ready = 1'b1;
            dpm_pp_pkg::ST_M1: begin
                w_mul_a           = r_sigma_now;
                w_mul_b           = r_eps;
                w_store_req.rd_en = 1'b1;
            end
            dpm_pp_pkg::ST_M3: begin
                w_mul_a = r_sample_scale;
                w_mul_b = r_x;
            end
            dpm_pp_pkg::ST_M2: begin
                w_mul_a = r_inv_alpha;
                w_mul_b = r_t;
            end
            dpm_pp_pkg::ST_X0: begin
                w_mul_a = r_base_coeff;
                w_mul_b = w_mul_q;
            end
            dpm_pp_pkg::ST_M5: begin
                w_mul_a = r_history_coeff;
                w_mul_b = r_d;
            end
            dpm_pp_pkg::ST_A5: w_store_req.wr_en = 1'b1;
            dpm_pp_pkg::ST_DONE: w_done_go = !r_out_valid || o_out.ready;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dpm_pp_pkg::ST_IDLE;
            r_pass      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_done_go) begin
                r_out_valid <= 1'b1;
                if (r_last && r_pass < dpm_pp_pkg::PASS_MAX) begin
                    r_pass <= r_pass + 1'b1;
                end
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // index reduction modulo the store depth, one compare-subtract per cycle
    always_comb begin
        w_mod_const = 32'(MAX_ELEMENTS) << (r_step - 1'b1);
    end

    assign w_addr = ADDR_W'(r_rem);

    always_ff @(posedge i_clk) begin
        if (w_in_ready && i_in.valid) begin
            r_index  <= i_in.element_index;
            r_rem    <= i_in.element_index;
            r_eps    <= i_in.eps_value;
            r_x      <= i_in.sample_value;
            r_last   <= i_in.last_of_pass;
            r_second <= (r_pass != '0) && !r_final_step;
            r_step   <= dpm_pp_pkg::STEP_W'(MOD_STEPS);
        end
        case (r_state)
            dpm_pp_pkg::ST_REDUCE: begin
                if (r_step != '0) begin
                    if (32'(r_rem) >= w_mod_const) begin
                        r_rem <= r_rem - w_mod_const[dpm_pp_pkg::INDEX_W-1:0];
                    end
                    r_step <= r_step - 1'b1;
                end
            end
            dpm_pp_pkg::ST_T: begin
                r_t <= dpm_pp_pkg::f_sat(AW'(r_x) - AW'(w_mul_q));
            end
            dpm_pp_pkg::ST_M2: begin
                r_acc <= AW'(w_mul_q);
            end
            dpm_pp_pkg::ST_X0: begin
                r_x0 <= w_mul_q;
                r_d  <= dpm_pp_pkg::f_sat(AW'(w_mul_q) - AW'(w_prev));
            end
            dpm_pp_pkg::ST_A4: begin
                r_acc <= r_acc - AW'(w_mul_q);
            end
            dpm_pp_pkg::ST_A5: begin
                if (r_second) begin
                    r_acc <= r_acc - AW'(w_mul_q);
                end
            end
            default: begin
            end
        endcase
        if (w_done_go) begin
            r_out_index <= r_index;
            r_out_value <= dpm_pp_pkg::f_sat(r_acc);
            r_out_last  <= r_last;
        end
    end

    dpm_pp_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_q   (w_mul_q)
    );

    dpm_pp_store #(
        .DEPTH  (MAX_ELEMENTS),
        .ADDR_W (ADDR_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_req     (w_store_req),
        .i_addr    (w_addr),
        .i_wr_data (r_x0),
        .o_rd_data (w_prev)
    );

    assign i_in.ready      = w_in_ready;
    assign o_out.valid     = r_out_valid;
    assign o_out.out_index = r_out_index;
    assign o_out.new_value = r_out_value;
    assign o_out.out_last  = r_out_last;

endmodule

/* src/dpm_pp_chk.sv */
// ----------------------------------------------------------------------------
// dpm_pp_chk
// port-level checks of the latent update, bound to the top level
// ----------------------------------------------------------------------------
module dpm_pp_chk (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  i_in_valid,
    input logic                                  i_in_ready,
    input logic                                  i_out_valid,
    input logic                                  i_out_ready,
    input logic        [dpm_pp_pkg::INDEX_W-1:0] i_out_index,
    input logic signed [dpm_pp_pkg::DATA_W-1:0]  i_new_value,
    input logic                                  i_out_last,
    input logic                                  i_cfg_ready
);

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_index)
            && $stable(i_new_value) && $stable(i_out_last))
        else $error("stalled result changed");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second request taken while busy");

    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(!i_in_ready))
        else $error("result appeared without work");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_ready)
        else $error("register port not ready");

endmodule

bind dpm_solver_pp_update dpm_pp_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_index (o_out.out_index),
    .i_new_value (o_out.new_value),
    .i_out_last  (o_out.out_last),
    .i_cfg_ready (i_cfg.ready)
);

/* tb/sv/dpm_solver_pp_update_test.sv */
// ----------------------------------------------------------------------------
// dpm_solver_pp_update_test
// self-checking bench for the second-order latent update: scoreboard with the
// estimate history and pass counter, directed corner cases, then random passes
// under several register settings and idle/stall mixes
// ----------------------------------------------------------------------------
module dpm_solver_pp_update_test;
    timeunit 1ns;
    timeprecision 1ps;

    import dpm_pp_pkg::*;

    localparam int STORE_DEPTH    = MAX_ELEMENTS_DEF;
    localparam int REPORT_LIMIT   = 10;
    localparam int CYCLE_LIMIT    = 600000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int LONG_HOLD      = 400;
    localparam int PHASES         = 8;
    localparam int PHASE_ELEMENTS = 168;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    localparam logic signed [DATA_W-1:0] DATA_MAX = 32'sh7fffffff;
    localparam logic signed [DATA_W-1:0] DATA_MIN = 32'sh80000000;
    localparam logic signed [DATA_W-1:0] Q_ONE    = 32'sd1048576;
    localparam logic signed [DATA_W-1:0] Q_HALF   = 32'sd524288;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;
    typedef enum int {MIX_TYPICAL, MIX_FULL, MIX_EXTREME} coeff_mix_e;

    typedef struct {
        logic        [INDEX_W-1:0] index;
        logic signed [DATA_W-1:0]  eps;
        logic signed [DATA_W-1:0]  sample;
        logic                      last;
    } element_t;

    typedef struct {
        logic        [INDEX_W-1:0] index;
        logic signed [DATA_W-1:0]  value;
        logic                      last;
    } update_t;

    class update_checker;
        logic signed [DATA_W-1:0] sigma, inv_alpha, scale, base, hist;
        logic                     final_flag;
        logic [PASS_W-1:0]        passes;
        logic signed [DATA_W-1:0] estimate_mem [STORE_DEPTH];
        update_t                  pending[$];
        int                       errors, checked, second_count;

        function new();
            sigma = '0;
            inv_alpha = INV_ALPHA_RST;
            scale = '0;
            base = '0;
            hist = '0;
            final_flag = 1'b0;
            passes = '0;
            errors = 0;
            checked = 0;
            second_count = 0;
        endfunction

        function logic signed [DATA_W-1:0] clamp32(longint v);
            if (v > 64'sd2147483647) begin
                return DATA_MAX;
            end else if (v < -64'sd2147483648) begin
                return DATA_MIN;
            end
            return v[DATA_W-1:0];
        endfunction

        // Q12.20 coefficient times Q8.24 data, round half up
        function logic signed [DATA_W-1:0] fx_mul(logic signed [DATA_W-1:0] c,
                                                 logic signed [DATA_W-1:0] d);
            longint p;
            p = longint'(c) * longint'(d) + 64'sd524288;
            return clamp32(p >>> 20);
        endfunction

        function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
            case (idx)
                CFG_SIGMA_NOW:     sigma = data;
                CFG_INV_ALPHA:     inv_alpha = data;
                CFG_SAMPLE_SCALE:  scale = data;
                CFG_BASE_COEFF:    base = data;
                CFG_HISTORY_COEFF: hist = data;
                CFG_FINAL_STEP:    final_flag = data[0];
                default: ;
            endcase
        endfunction

        function void report_fault(string text);
            errors++;
            if (errors <= REPORT_LIMIT) begin
                $display("%s", text);
            end
        endfunction

        function void note_element(element_t e);
            logic signed [DATA_W-1:0] t, x0, d;
            longint                   acc;
            int                       slot;
            update_t                  r;
            slot = int'(e.index) % STORE_DEPTH;
            t = clamp32(longint'(e.sample) - longint'(fx_mul(sigma, e.eps)));
            x0 = fx_mul(inv_alpha, t);
            acc = longint'(fx_mul(scale, e.sample)) - longint'(fx_mul(base, x0));
            if (passes >= 1 && final_flag == 1'b0) begin
                d = clamp32(longint'(x0) - longint'(estimate_mem[slot]));
                acc -= longint'(fx_mul(hist, d));
                second_count++;
            end
            estimate_mem[slot] = x0;
            // order decided above, counter advances after the element
            if (e.last && passes < PASS_MAX) begin
                passes++;
            end
            r.index = e.index;
            r.value = clamp32(acc);
            r.last = e.last;
            pending = {pending, r};
        endfunction

        function void check_update(update_t got);
            update_t want;
            if (pending.size() == 0) begin
                report_fault($sformatf("update with nothing pending: idx=%0d value=%0d last=%0d",
                                       got.index, got.value, got.last));
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got.index !== want.index || got.value !== want.value
                    || got.last !== want.last) begin
                report_fault($sformatf({"update mismatch: expected idx=%0d value=%0d last=%0d,",
                                        " got idx=%0d value=%0d last=%0d"},
                                       want.index, want.value, want.last,
                                       got.index, got.value, got.last));
            end
        endfunction

        function void finish_check();
            if (pending.size() != 0) begin
                report_fault($sformatf("%0d updates never arrived", pending.size()));
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    dpm_pp_in_if  in_ch();
    dpm_pp_out_if out_ch();
    dpm_pp_cfg_if cfg_ch();

    dpm_solver_pp_update DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    update_checker board = new();

    int  idle_pct = 0;
    int  stall_pct = 0;
    int  hold_request = 0;
    int  sent_count = 0;
    int  settings_count = 0;
    bit  written_slot [STORE_DEPTH];
    logic [INDEX_W-1:0] written_list[$];

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("timeout after %0d cycles", CYCLE_LIMIT);
        $display("dpm_solver_pp_update_test: errors");
        $finish;
    end

    initial begin : result_sink
        int      hold_left;
        update_t got;
        hold_left = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid === 1'b1 && out_ch.ready) begin
                got.index = out_ch.out_index;
                got.value = out_ch.new_value;
                got.last = out_ch.out_last;
                board.check_update(got);
            end
            if (hold_request > 0) begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    function automatic element_t mk(input logic [INDEX_W-1:0] idx,
                                    input logic signed [DATA_W-1:0] eps,
                                    input logic signed [DATA_W-1:0] x,
                                    input logic last);
        element_t e;
        e.index = idx;
        e.eps = eps;
        e.sample = x;
        e.last = last;
        return e;
    endfunction

    function automatic logic signed [DATA_W-1:0] rand_data();
        case ($urandom_range(9))
            0: return DATA_MAX;
            1: return DATA_MIN;
            2: return '0;
            3, 4: return $urandom;
            default: return int'($urandom_range(0, 32'h0fff_ffff)) - 32'sh0800_0000;
        endcase
    endfunction

    function automatic logic signed [DATA_W-1:0] rand_coeff(input coeff_mix_e mix);
        case (mix)
            MIX_TYPICAL: return int'($urandom_range(0, 32'h007f_ffff)) - 32'sh0040_0000;
            MIX_FULL:    return $urandom;
            default: begin
                case ($urandom_range(4))
                    0: return DATA_MAX;
                    1: return DATA_MIN;
                    2: return '0;
                    3: return Q_ONE;
                    default: return -Q_ONE;
                endcase
            end
        endcase
    endfunction

    function automatic logic [INDEX_W-1:0] rand_index();
        case ($urandom_range(3))
            0: return INDEX_W'($urandom_range(63));
            1: begin
                if (written_list.size() > 0) begin
                    return written_list[$urandom_range(written_list.size() - 1)];
                end
                return INDEX_W'($urandom_range((1 << INDEX_W) - 1));
            end
            default: return INDEX_W'($urandom_range((1 << INDEX_W) - 1));
        endcase
    endfunction

    // in second order only indexes with a stored estimate may be read
    function automatic logic [INDEX_W-1:0] pick_index(input logic [INDEX_W-1:0] raw);
        if (board.passes >= 1 && board.final_flag == 1'b0
                && !written_slot[int'(raw) % STORE_DEPTH]) begin
            return written_list[$urandom_range(written_list.size() - 1)];
        end
        return raw;
    endfunction

    task automatic set_idling(input idle_mode_e mode);
        idle_pct = (mode == IDLE_SENDER) ? 59 : (mode == IDLE_BOTH) ? 7 : 0;
        stall_pct = (mode == IDLE_RECEIVER) ? 59 : (mode == IDLE_BOTH) ? 7 : 0;
    endtask

    task automatic send_element(input element_t e);
        int slot;
        while ($urandom_range(99) < idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.element_index <= e.index;
        in_ch.eps_value <= e.eps;
        in_ch.sample_value <= e.sample;
        in_ch.last_of_pass <= e.last;
        @(posedge i_clk);
        while (in_ch.ready !== 1'b1) @(posedge i_clk);
        board.note_element(e);
        sent_count++;
        slot = int'(e.index) % STORE_DEPTH;
        if (!written_slot[slot]) begin
            written_slot[slot] = 1'b1;
            written_list = {written_list, e.index};
        end
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= data;
        @(posedge i_clk);
        while (cfg_ch.ready !== 1'b1) @(posedge i_clk);
        board.apply_reg(idx, data);
    endtask

    task automatic load_settings(input logic signed [DATA_W-1:0] sig,
                                 input logic signed [DATA_W-1:0] ia,
                                 input logic signed [DATA_W-1:0] sc,
                                 input logic signed [DATA_W-1:0] bs,
                                 input logic signed [DATA_W-1:0] hs,
                                 input logic fin, input bit with_spare);
        cfg_write(CFG_SIGMA_NOW, sig);
        cfg_write(CFG_INV_ALPHA, ia);
        cfg_write(CFG_SAMPLE_SCALE, sc);
        cfg_write(CFG_BASE_COEFF, bs);
        cfg_write(CFG_HISTORY_COEFF, hs);
        cfg_write(CFG_FINAL_STEP, {31'd0, fin});
        if (with_spare) begin
            cfg_write(CFG_SPARE_LO, $urandom);
            cfg_write(CFG_SPARE_HI, $urandom);
        end
        cfg_ch.valid <= 1'b0;
        settings_count++;
    endtask

    initial begin : stimulus
        logic [INDEX_W-1:0] work[$];
        coeff_mix_e         mix;
        logic               fin;
        int                 target;

        i_rst_n <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.element_index <= '0;
        in_ch.eps_value <= '0;
        in_ch.sample_value <= '0;
        in_ch.last_of_pass <= 1'b0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= '0;
        cfg_ch.data <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings, first pass
        set_idling(IDLE_NONE);
        send_element(mk(16'h0000, DATA_MAX, DATA_MIN, 1'b0));
        send_element(mk(16'hffff, DATA_MIN, DATA_MAX, 1'b0));
        wait_drained();

        load_settings(DATA_MAX, DATA_MIN, DATA_MAX, DATA_MIN, DATA_MAX, 1'b0, 1'b1);
        send_element(mk(16'h0000, DATA_MIN, DATA_MAX, 1'b0));
        send_element(mk(16'hffff, '0, '0, 1'b0));
        send_element(mk(16'h5555, -32'sd1, 32'sd1, 1'b0));
        // last element is still first order, the next one is second order
        send_element(mk(16'haaaa, DATA_MAX, DATA_MAX, 1'b1));
        send_element(mk(16'h5555, DATA_MAX, DATA_MIN, 1'b0));
        wait_drained();

        load_settings(Q_HALF, Q_ONE, Q_ONE, -Q_ONE, DATA_MIN, 1'b0, 1'b0);
        send_element(mk(16'h0000, DATA_MAX, DATA_MIN, 1'b0));
        send_element(mk(16'hffff, DATA_MIN, DATA_MAX, 1'b0));
        send_element(mk(16'haaaa, '0, '0, 1'b0));
        send_element(mk(16'h5555, 32'sd1, -32'sd1, 1'b1));
        send_element(mk(16'h0000, '0, DATA_MAX, 1'b1));
        wait_drained();

        // final step falls back to first order
        load_settings(DATA_MIN, DATA_MAX, DATA_MIN, DATA_MAX, DATA_MAX, 1'b1, 1'b1);
        send_element(mk(16'h0f0f, DATA_MAX, DATA_MAX, 1'b0));
        send_element(mk(16'hf0f0, DATA_MIN, DATA_MIN, 1'b1));
        send_element(mk(16'h1234, rand_data(), rand_data(), 1'b0));
        wait_drained();

        load_settings('0, '0, '0, '0, Q_ONE, 1'b0, 1'b0);
        send_element(mk(16'h0f0f, DATA_MIN, DATA_MAX, 1'b0));
        send_element(mk(16'hf0f0, DATA_MAX, DATA_MIN, 1'b1));

        for (int p = 0; p < PHASES; p++) begin
            wait_drained();
            mix = coeff_mix_e'(p % 3);
            fin = (p == 2 || p == 5 || $urandom_range(7) == 0);
            load_settings(rand_coeff(mix), rand_coeff(mix), rand_coeff(mix),
                          rand_coeff(mix), rand_coeff(mix), fin, 1'b0);
            set_idling(idle_mode_e'((p + p / 4) % 4));
            if (p == 0) begin
                hold_request = LONG_HOLD;
            end
            work.delete();
            repeat ($urandom_range(6, 24)) work = {work, pick_index(rand_index())};
            target = sent_count + PHASE_ELEMENTS;
            while (sent_count < target) begin
                if ($urandom_range(9) < 8) begin
                    foreach (work[i]) begin
                        send_element(mk(work[i], rand_data(), rand_data(),
                                        i == work.size() - 1));
                    end
                end else begin
                    // stray elements, sometimes with a misplaced last flag
                    repeat ($urandom_range(1, 5)) begin
                        send_element(mk(pick_index(rand_index()), rand_data(), rand_data(),
                                        $urandom_range(9) == 0));
                    end
                end
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        board.finish_check();
        $display("checked %0d of %0d elements under %0d register settings, %0d second order",
                 board.checked, sent_count, settings_count, board.second_count);
        $display("idle mixes: none, sender, receiver, both; one %0d-cycle result hold-off",
                 LONG_HOLD);
        if (board.errors == 0) begin
            $display("dpm_solver_pp_update_test: clean");
        end else begin
            $display("dpm_solver_pp_update_test: errors");
        end
        $finish;
    end

endmodule

/* sim.f */
src/dpm_pp_pkg.sv
src/dpm_pp_if.sv
src/dpm_pp_mul.sv
src/dpm_pp_store.sv
src/dpm_solver_pp_update.sv
src/dpm_pp_chk.sv
tb/sv/dpm_solver_pp_update_test.sv
